// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the look-at view matrix core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hdl/lavm_pkg.sv -----
// ---------------------------------------------------------------------------
// lavm_pkg
// Shared constants of the look-at view matrix core.
// ---------------------------------------------------------------------------
package lavm_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_W = 32;

	localparam logic [1:0] GROUP_FIRST = 2'd0;
	localparam logic [1:0] GROUP_LAST = 2'd3;

endpackage

// ----- hdl/lavm_norm.sv -----
// ---------------------------------------------------------------------------
// lavm_norm
// Pipelined 3-vector normaliser: scale, square sum, square root, divide.
// ---------------------------------------------------------------------------
module lavm_norm #(
	parameter int IN_W = 33,
	parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF,
	parameter int SIDE_W = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [2:0][IN_W-1:0]       in_vec,
	input  logic [SIDE_W-1:0]          in_side,
	output logic                       out_valid,
	output logic [2:0][FRAC_BITS+1:0]  out_vec,
	output logic                       out_zero,
	output logic [SIDE_W-1:0]          out_side
);

	localparam int M_W = 31;
	localparam int P_W = $clog2(IN_W);
	localparam int SQ_W = 64;
	localparam int SQ_N = 32;
	localparam int L_W = 32;
	localparam int Q_W = FRAC_BITS + 1;
	localparam int NUM_W = FRAC_BITS + L_W;
	localparam int OUT_W = FRAC_BITS + 2;
	localparam int EXT_W = IN_W + M_W - 1;

	typedef struct packed {
		logic [2:0]            sgn;
		logic                  zero;
		logic [2:0][M_W-1:0]   m;
		logic [SIDE_W-1:0]     side;
	} car_a_t;

	typedef struct packed {
		logic [2:0]            sgn;
		logic                  zero;
		logic [SIDE_W-1:0]     side;
	} car_b_t;

	function automatic logic [P_W-1:0] top_bit(input logic [IN_W-1:0] v);
		logic [P_W-1:0] p;
		p = '0;
		for (int i = 0; i < IN_W; i++) begin
			if (v[i]) p = P_W'(i);
		end
		return p;
	endfunction

	// stage 1: magnitudes and leading one of their OR
	logic [2:0][IN_W-1:0] mag_c;
	logic [IN_W-1:0]      any_c;

	always_comb begin
		any_c = '0;
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = in_vec[i][IN_W-1] ? (~in_vec[i] + IN_W'(1)) : in_vec[i];
			any_c = any_c | mag_c[i];
		end
	end

	logic                  v_s1, zero_s1;
	logic [2:0]            sgn_s1;
	logic [2:0][IN_W-1:0]  mag_s1;
	logic [P_W-1:0]        p_s1;
	logic [SIDE_W-1:0]     side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= (any_c == '0);
			sgn_s1 <= {in_vec[2][IN_W-1], in_vec[1][IN_W-1], in_vec[0][IN_W-1]};
			mag_s1 <= mag_c;
			p_s1 <= top_bit(any_c);
			side_s1 <= in_side;
		end
	end

	// stage 2: bring the leading one to bit 30
	logic [EXT_W-1:0]     ext_c [3];
	logic                 v_s2, zero_s2;
	logic [2:0]           sgn_s2;
	logic [2:0][M_W-1:0]  m_s2;
	logic [SIDE_W-1:0]    side_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ext_c[i] = {mag_s1[i], {(M_W-1){1'b0}}} >> p_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s2 <= zero_s1;
			sgn_s2 <= sgn_s1;
			for (int i = 0; i < 3; i++) m_s2[i] <= ext_c[i][M_W-1:0];
			side_s2 <= side_s1;
		end
	end

	// stage 3: squares
	logic                   v_s3, zero_s3;
	logic [2:0]             sgn_s3;
	logic [2:0][M_W-1:0]    m_s3;
	logic [2:0][2*M_W-1:0]  sq_s3;
	logic [SIDE_W-1:0]      side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s3 <= zero_s2;
			sgn_s3 <= sgn_s2;
			m_s3 <= m_s2;
			for (int i = 0; i < 3; i++) sq_s3[i] <= m_s2[i] * m_s2[i];
			side_s3 <= side_s2;
		end
	end

	// stage 4 onwards: sum, then one square-root digit per stage
	logic [SQ_W-1:0] sx [0:SQ_N];
	logic [SQ_W-1:0] sr [0:SQ_N];
	logic            sv [0:SQ_N];
	car_a_t          sc [0:SQ_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sv[0] <= 1'b0;
		else if (en) sv[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx[0] <= SQ_W'(sq_s3[0]) + SQ_W'(sq_s3[1]) + SQ_W'(sq_s3[2]);
			sr[0] <= '0;
			sc[0] <= '{sgn: sgn_s3, zero: zero_s3, m: m_s3, side: side_s3};
		end
	end

	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * (SQ_N - 1 - k));
		logic [SQ_W-1:0] trial;
		assign trial = sr[k] + BITV;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv[k+1] <= 1'b0;
			else if (en) sv[k+1] <= sv[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sc[k+1] <= sc[k];
				if (sx[k] >= trial) begin
					sx[k+1] <= sx[k] - trial;
					sr[k+1] <= (sr[k] >> 1) + BITV;
				end else begin
					sx[k+1] <= sx[k];
					sr[k+1] <= sr[k] >> 1;
				end
			end
		end
	end

	// dividend set-up, then one quotient bit per stage for all three lanes
	logic [L_W-1:0]          len_c;
	logic [2:0][NUM_W-1:0]   drem [0:Q_W];
	logic [2:0][Q_W-1:0]     dq   [0:Q_W];
	logic [L_W-1:0]          dlen [0:Q_W];
	logic                    dv   [0:Q_W];
	car_b_t                  dc   [0:Q_W];

	assign len_c = sr[SQ_N][L_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv[0] <= 1'b0;
		else if (en) dv[0] <= sv[SQ_N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				drem[0][i] <= {1'b0, sc[SQ_N].m[i], {FRAC_BITS{1'b0}}}
					+ NUM_W'(len_c >> 1);
			end
			dq[0] <= '0;
			dlen[0] <= len_c;
			dc[0] <= '{sgn: sc[SQ_N].sgn, zero: sc[SQ_N].zero, side: sc[SQ_N].side};
		end
	end

	for (genvar j = 0; j < Q_W; j++) begin : g_div
		localparam int QB = Q_W - 1 - j;
		logic [NUM_W-1:0] trial;
		assign trial = NUM_W'(dlen[j]) << QB;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv[j+1] <= 1'b0;
			else if (en) dv[j+1] <= dv[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dlen[j+1] <= dlen[j];
				dc[j+1] <= dc[j];
				for (int l = 0; l < 3; l++) begin
					if (drem[j][l] >= trial) begin
						drem[j+1][l] <= drem[j][l] - trial;
						dq[j+1][l] <= dq[j][l] | (Q_W'(1) << QB);
					end else begin
						drem[j+1][l] <= drem[j][l];
						dq[j+1][l] <= dq[j][l];
					end
				end
			end
		end
	end

	// restore signs; drop everything for a zero vector
	logic [2:0][OUT_W-1:0] qx_c;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			qx_c[l] = OUT_W'(dq[Q_W][l]);
			if (dc[Q_W].zero) qx_c[l] = '0;
			else if (dc[Q_W].sgn[l]) qx_c[l] = ~qx_c[l] + OUT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= dv[Q_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_vec <= qx_c;
			out_zero <= dc[Q_W].zero;
			out_side <= dc[Q_W].side;
		end
	end

endmodule

// ----- hdl/look_at_view_matrix_core.sv -----
// ---------------------------------------------------------------------------
// look_at_view_matrix_core
// Fixed-point look-at view matrix builder, four beats of matrix words per item.
// ---------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | sink      | in_valid / in_stall   | eye_*, center_*, up_* (Q16.16)
//  out     | source    | out_valid / out_stall | group_index, word_0..3, flags
//
//  The output serialiser sets the item rate: it loads a new matrix only once
//  the last group of the one it holds is taken. Most of the pipeline lies in
//  the two chained normalisers (32 square-root stages and FRAC_BITS+1 divide stages).
//  Reset clears only valid bits and the serialiser state.
//  A stall on the output freezes the whole pipeline once the last stage holds
//  an item that the serialiser cannot take; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module look_at_view_matrix_core #(
	parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] center_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         group_index,
	output logic signed [31:0] word_0,
	output logic signed [31:0] word_1,
	output logic signed [31:0] word_2,
	output logic signed [31:0] word_3,
	output logic               last_group,
	output logic               degenerate
);

	localparam int W = lavm_pkg::WORD_W;
	localparam int V_W = FRAC_BITS + 2;     // unit vector component
	localparam int P1_W = 2 * V_W;          // product of two components
	localparam int SR_W = P1_W + 1;         // cross product component
	localparam int U_W = FRAC_BITS + 5;     // rounded u component
	localparam int DW = FRAC_BITS + 39;     // dot-product accumulator
	localparam int D_W = W + 1;             // exact centre minus eye

	localparam logic signed [DW-1:0] W_MAX = {{(DW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [DW-1:0] W_MIN = {{(DW-31){1'b1}}, {31{1'b0}}};

	typedef struct packed {
		logic [2:0][V_W-1:0] f;
		logic [2:0][W-1:0]   eye;
		logic                deg;
	} side_c_t;

	function automatic logic signed [DW-1:0] rnd(input logic signed [DW-1:0] v);
		logic [DW-1:0] mg;
		mg = v[DW-1] ? (~v + DW'(1)) : v;
		mg = (mg + (DW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return v[DW-1] ? (~mg + DW'(1)) : mg;
	endfunction

	function automatic logic [W-1:0] sat(input logic signed [DW-1:0] v);
		logic [W-1:0] r;
		if (v > W_MAX) r = W_MAX[W-1:0];
		else if (v < W_MIN) r = W_MIN[W-1:0];
		else r = v[W-1:0];
		return r;
	endfunction

	// Pipeline advance: move everything unless the tail holds an item the
	// serialiser cannot take this cycle.
	logic en, load, v_s9, busy_q;
	logic [1:0] grp_q;

	assign load = v_s9 && (!busy_q || (out_valid && !out_stall && last_group));
	assign en = !v_s9 || load;
	assign in_stall = !en;

	// Stage 1: register the beat, form centre minus eye exactly.
	logic                v_s1;
	logic [2:0][D_W-1:0] d_s1;
	logic [2:0][W-1:0]   eye_s1, up_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eye_s1 <= {eye_z, eye_y, eye_x};
			up_s1 <= {up_z, up_y, up_x};
			d_s1[0] <= {center_x[W-1], center_x} - {eye_x[W-1], eye_x};
			d_s1[1] <= {center_y[W-1], center_y} - {eye_y[W-1], eye_y};
			d_s1[2] <= {center_z[W-1], center_z} - {eye_z[W-1], eye_z};
		end
	end

	// Normalise f and up side by side; eye rides along with f.
	logic                 fa_valid, fa_zero, ub_zero;
	logic                 ub_valid, ub_side;
	logic [2:0][V_W-1:0]  fa_vec, ub_vec;
	logic [2:0][W-1:0]    fa_eye;

	lavm_norm #(.IN_W(D_W), .FRAC_BITS(FRAC_BITS), .SIDE_W(3 * W)) u_norm_f (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .in_vec(d_s1), .in_side(eye_s1),
		.out_valid(fa_valid), .out_vec(fa_vec), .out_zero(fa_zero), .out_side(fa_eye)
	);

	lavm_norm #(.IN_W(W), .FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_norm_up (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .in_vec(up_s1), .in_side(1'b0),
		.out_valid(ub_valid), .out_vec(ub_vec), .out_zero(ub_zero), .out_side(ub_side)
	);

	// Stage 2: partial products of f x up.
	logic                    v_s2, deg_s2;
	logic signed [P1_W-1:0]  pf_s2 [6];
	logic [2:0][V_W-1:0]     f_s2;
	logic [2:0][W-1:0]       eye_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= fa_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pf_s2[0] <= $signed(fa_vec[1]) * $signed(ub_vec[2]);
			pf_s2[1] <= $signed(fa_vec[2]) * $signed(ub_vec[1]);
			pf_s2[2] <= $signed(fa_vec[2]) * $signed(ub_vec[0]);
			pf_s2[3] <= $signed(fa_vec[0]) * $signed(ub_vec[2]);
			pf_s2[4] <= $signed(fa_vec[0]) * $signed(ub_vec[1]);
			pf_s2[5] <= $signed(fa_vec[1]) * $signed(ub_vec[0]);
			f_s2 <= fa_vec;
			eye_s2 <= fa_eye;
			deg_s2 <= fa_zero | ub_zero;
		end
	end

	// Stage 3: exact cross product, ready for the s normaliser.
	logic                 v_s3;
	logic [2:0][SR_W-1:0] sraw_s3;
	side_c_t              side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sraw_s3[i] <= SR_W'(pf_s2[2*i]) - SR_W'(pf_s2[2*i+1]);
			end
			side_s3 <= '{f: f_s2, eye: eye_s2, deg: deg_s2};
		end
	end

	logic                 sc_valid, sc_zero;
	logic [2:0][V_W-1:0]  sc_vec;
	side_c_t              sc_side;

	lavm_norm #(.IN_W(SR_W), .FRAC_BITS(FRAC_BITS), .SIDE_W($bits(side_c_t))) u_norm_s (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s3), .in_vec(sraw_s3), .in_side(side_s3),
		.out_valid(sc_valid), .out_vec(sc_vec), .out_zero(sc_zero), .out_side(sc_side)
	);

	// Stage 4: products for s x f and for the s and f dot products.
	logic                   v_s4, deg_s4;
	logic signed [P1_W-1:0] psf_s4 [6];
	logic signed [DW-1:0]   pse_s4 [3];
	logic signed [DW-1:0]   pfe_s4 [3];
	logic [2:0][V_W-1:0]    s_s4, f_s4;
	logic [2:0][W-1:0]      eye_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= sc_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			psf_s4[0] <= $signed(sc_vec[1]) * $signed(sc_side.f[2]);
			psf_s4[1] <= $signed(sc_vec[2]) * $signed(sc_side.f[1]);
			psf_s4[2] <= $signed(sc_vec[2]) * $signed(sc_side.f[0]);
			psf_s4[3] <= $signed(sc_vec[0]) * $signed(sc_side.f[2]);
			psf_s4[4] <= $signed(sc_vec[0]) * $signed(sc_side.f[1]);
			psf_s4[5] <= $signed(sc_vec[1]) * $signed(sc_side.f[0]);
			for (int i = 0; i < 3; i++) begin
				pse_s4[i] <= $signed(sc_vec[i]) * $signed(sc_side.eye[i]);
				pfe_s4[i] <= $signed(sc_side.f[i]) * $signed(sc_side.eye[i]);
			end
			s_s4 <= sc_vec;
			f_s4 <= sc_side.f;
			eye_s4 <= sc_side.eye;
			deg_s4 <= sc_side.deg | sc_zero;
		end
	end

	// Stage 5: s x f exact, s.eye and f.eye sums.
	logic                   v_s5, deg_s5;
	logic signed [SR_W-1:0] uraw_s5 [3];
	logic signed [DW-1:0]   ds_s5, df_s5;
	logic [2:0][V_W-1:0]    s_s5, f_s5;
	logic [2:0][W-1:0]      eye_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				uraw_s5[i] <= SR_W'(psf_s4[2*i]) - SR_W'(psf_s4[2*i+1]);
			end
			ds_s5 <= pse_s4[0] + pse_s4[1] + pse_s4[2];
			df_s5 <= pfe_s4[0] + pfe_s4[1] + pfe_s4[2];
			s_s5 <= s_s4;
			f_s5 <= f_s4;
			eye_s5 <= eye_s4;
			deg_s5 <= deg_s4;
		end
	end

	// Stage 6: round u, finish the s and f translation words.
	logic                  v_s6, deg_s6;
	logic [2:0][U_W-1:0]   u_s6;
	logic [W-1:0]          wds_s6, wdf_s6;
	logic [2:0][V_W-1:0]   s_s6, f_s6;
	logic [2:0][W-1:0]     eye_s6;
	logic signed [DW-1:0]  ur_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) ur_c[i] = rnd(DW'(uraw_s5[i]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) u_s6[i] <= ur_c[i][U_W-1:0];
			wds_s6 <= sat(-rnd(ds_s5));
			wdf_s6 <= sat(rnd(df_s5));
			s_s6 <= s_s5;
			f_s6 <= f_s5;
			eye_s6 <= eye_s5;
			deg_s6 <= deg_s5;
		end
	end

	// Stage 7: u.eye products.
	logic                  v_s7, deg_s7;
	logic signed [DW-1:0]  pue_s7 [3];
	logic [2:0][U_W-1:0]   u_s7;
	logic [W-1:0]          wds_s7, wdf_s7;
	logic [2:0][V_W-1:0]   s_s7, f_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pue_s7[i] <= $signed(u_s6[i]) * $signed(eye_s6[i]);
			end
			u_s7 <= u_s6;
			wds_s7 <= wds_s6;
			wdf_s7 <= wdf_s6;
			s_s7 <= s_s6;
			f_s7 <= f_s6;
			deg_s7 <= deg_s6;
		end
	end

	// Stage 8: u.eye sum.
	logic                  v_s8, deg_s8;
	logic signed [DW-1:0]  du_s8;
	logic [2:0][U_W-1:0]   u_s8;
	logic [W-1:0]          wds_s8, wdf_s8;
	logic [2:0][V_W-1:0]   s_s8, f_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			du_s8 <= pue_s7[0] + pue_s7[1] + pue_s7[2];
			u_s8 <= u_s7;
			wds_s8 <= wds_s7;
			wdf_s8 <= wdf_s7;
			s_s8 <= s_s7;
			f_s8 <= f_s7;
			deg_s8 <= deg_s7;
		end
	end

	// Stage 9: last translation word; every word now in 32-bit form.
	logic                 deg_s9;
	logic [2:0][W-1:0]    s_s9, u_s9, nf_s9;
	logic [W-1:0]         wds_s9, wdu_s9, wdf_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (en) v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				s_s9[i] <= W'($signed(s_s8[i]));
				u_s9[i] <= W'($signed(u_s8[i]));
				nf_s9[i] <= W'(-$signed(f_s8[i]));
			end
			wds_s9 <= wds_s8;
			wdu_s9 <= sat(-rnd(du_s8));
			wdf_s9 <= wdf_s8;
			deg_s9 <= deg_s8;
		end
	end

	// Output serialiser: hold one matrix, advance one group per beat.
	logic [2:0][W-1:0] s_q, u_q, nf_q;
	logic [W-1:0]      wds_q, wdu_q, wdf_q;
	logic              deg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			grp_q <= lavm_pkg::GROUP_FIRST;
		end else if (load) begin
			busy_q <= 1'b1;
			grp_q <= lavm_pkg::GROUP_FIRST;
		end else if (out_valid && !out_stall) begin
			if (last_group) busy_q <= 1'b0;
			grp_q <= grp_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			s_q <= s_s9;
			u_q <= u_s9;
			nf_q <= nf_s9;
			wds_q <= wds_s9;
			wdu_q <= wdu_s9;
			wdf_q <= wdf_s9;
			deg_q <= deg_s9;
		end
	end

	assign out_valid = busy_q;
	assign group_index = grp_q;
	assign last_group = (grp_q == lavm_pkg::GROUP_LAST);
	assign degenerate = deg_q;

	always_comb begin
		if (last_group) begin
			word_0 = wds_q;
			word_1 = wdu_q;
			word_2 = wdf_q;
			word_3 = W'(1) << FRAC_BITS;
		end else begin
			word_0 = s_q[grp_q];
			word_1 = u_q[grp_q];
			word_2 = nf_q[grp_q];
			word_3 = '0;
		end
	end

	// A stall at the input means a finished item is waiting on a busy serialiser.
	`ASSERT_HOLDS(a_stall_cause, clk, arst_n, in_stall, v_s9 && busy_q)
	// The f and up normalisers run in lockstep.
	`ASSERT_HOLDS(a_norm_lockstep, clk, arst_n, ub_valid || fa_valid, ub_valid && fa_valid && !ub_side)
	// A new matrix always opens with its first group.
	`ASSERT_NEXT(a_load_first, clk, arst_n, load, out_valid && group_index == lavm_pkg::GROUP_FIRST)
	// Groups advance by one within a matrix.
	`ASSERT_NEXT(a_group_step, clk, arst_n, out_valid && !out_stall && !last_group, out_valid && group_index == $past(group_index) + 2'd1)

endmodule

// ----- test/lavm_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lavm_checker
// Watches both channels of the look-at view matrix core. Every accepted input
// beat is turned into four predicted matrix rows. Every accepted output beat
// is compared field by field with the oldest predicted row.
// ---------------------------------------------------------------------------
module lavm_checker #(
	parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] center_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         group_index,
	input  logic signed [31:0] word_0,
	input  logic signed [31:0] word_1,
	input  logic signed [31:0] word_2,
	input  logic signed [31:0] word_3,
	input  logic               last_group,
	input  logic               degenerate,
	output int                 errors,
	output int                 rows_pending
);

	typedef longint vec3_t [3];

	typedef struct {
		logic [1:0]                          grp;
		logic signed [lavm_pkg::WORD_W-1:0]  w [4];
		logic                                last;
		logic                                deg;
	} matrix_row_t;

	matrix_row_t row_queue[$];

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// Scale so the largest magnitude tops out at bit 30, then divide by the
	// rounded-down length. Returns 1 on a zero vector, which is left as is.
	function automatic bit unit_vector(ref vec3_t v);
		longint unsigned m [3];
		longint unsigned mx, acc, len, q;
		int p;
		mx = 0;
		acc = 0;
		p = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = magnitude(v[i]);
			if (m[i] > mx)
				mx = m[i];
		end
		if (mx == 0)
			return 1'b1;
		while (p < 63 && (mx >> (p + 1)) != 0)
			p++;
		for (int i = 0; i < 3; i++) begin
			if (p > 30)
				m[i] = m[i] >> (p - 30);
			else
				m[i] = m[i] << (30 - p);
			acc += m[i] * m[i];
		end
		len = int_sqrt(acc);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
			v[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1'b0;
	endfunction

	function automatic longint drop_frac(longint v);
		longint unsigned m;
		m = (magnitude(v) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint cross_at(vec3_t a, vec3_t b, int i);
		int j, k;
		j = (i + 1) % 3;
		k = (i + 2) % 3;
		return a[j] * b[k] - a[k] * b[j];
	endfunction

	task automatic predict_matrix();
		vec3_t eye, fwd, upv, side, upr;
		bit deg;
		longint ds, du, df;
		matrix_row_t r;
		eye[0] = eye_x;
		eye[1] = eye_y;
		eye[2] = eye_z;
		fwd[0] = longint'(center_x) - eye[0];
		fwd[1] = longint'(center_y) - eye[1];
		fwd[2] = longint'(center_z) - eye[2];
		upv[0] = up_x;
		upv[1] = up_y;
		upv[2] = up_z;
		deg = unit_vector(fwd);
		deg |= unit_vector(upv);
		for (int i = 0; i < 3; i++)
			side[i] = cross_at(fwd, upv, i);
		deg |= unit_vector(side);
		for (int i = 0; i < 3; i++)
			upr[i] = drop_frac(cross_at(side, fwd, i));
		ds = 0;
		du = 0;
		df = 0;
		for (int i = 0; i < 3; i++) begin
			ds += side[i] * eye[i];
			du += upr[i] * eye[i];
			df += fwd[i] * eye[i];
		end
		for (int g = 0; g < 4; g++) begin
			r.grp = g[1:0];
			r.last = (r.grp == lavm_pkg::GROUP_LAST);
			r.deg = deg;
			if (g < 3) begin
				r.w[0] = clamp32(side[g]);
				r.w[1] = clamp32(upr[g]);
				r.w[2] = clamp32(-fwd[g]);
				r.w[3] = '0;
			end else begin
				r.w[0] = clamp32(-drop_frac(ds));
				r.w[1] = clamp32(-drop_frac(du));
				r.w[2] = clamp32(drop_frac(df));
				r.w[3] = 32'sd1 <<< FRAC_BITS;
			end
			row_queue.push_back(r);
		end
	endtask

	task automatic flag_error(string what, longint want, longint got);
		errors++;
		if (errors <= 10)
			$display("%0t: %s expected %h got %h", $realtime, what, want, got);
	endtask

	initial errors = 0;

	always @(posedge clk) begin
		matrix_row_t e;
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_matrix();
			if (out_valid && !out_stall) begin
				if (row_queue.size() == 0) begin
					flag_error("unexpected beat, group", 0, group_index);
				end else begin
					e = row_queue.pop_front();
					if (group_index !== e.grp)
						flag_error("group_index", e.grp, group_index);
					if (word_0 !== e.w[0])
						flag_error("word_0", e.w[0], word_0);
					if (word_1 !== e.w[1])
						flag_error("word_1", e.w[1], word_1);
					if (word_2 !== e.w[2])
						flag_error("word_2", e.w[2], word_2);
					if (word_3 !== e.w[3])
						flag_error("word_3", e.w[3], word_3);
					if (last_group !== e.last)
						flag_error("last_group", e.last, last_group);
					if (degenerate !== e.deg)
						flag_error("degenerate", e.deg, degenerate);
				end
			end
		end
		rows_pending <= row_queue.size();
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the look-at view matrix core. Directed corner
// cases first, then random camera set-ups under several idling phases; a
// side checker predicts and compares every output beat.
// ---------------------------------------------------------------------------
module tb;

	localparam int LATENCY = 2 * (lavm_pkg::FRAC_BITS_DEF + 39) + 10;
	localparam int RANDOM_ITEMS = 180;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] eye_x, eye_y, eye_z;
	logic signed [31:0] center_x, center_y, center_z;
	logic signed [31:0] up_x, up_y, up_z;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         group_index;
	logic signed [31:0] word_0, word_1, word_2, word_3;
	logic               last_group;
	logic               degenerate;
	int                 errors;
	int                 rows_pending;

	// idling odds in percent, changed per phase
	int send_idle_pct;
	int recv_stall_pct;

	look_at_view_matrix_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
		.center_x(center_x), .center_y(center_y), .center_z(center_z),
		.up_x(up_x), .up_y(up_y), .up_z(up_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.group_index(group_index),
		.word_0(word_0), .word_1(word_1), .word_2(word_2), .word_3(word_3),
		.last_group(last_group), .degenerate(degenerate)
	);

	lavm_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
		.center_x(center_x), .center_y(center_y), .center_z(center_z),
		.up_x(up_x), .up_y(up_y), .up_z(up_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.group_index(group_index),
		.word_0(word_0), .word_1(word_1), .word_2(word_2), .word_3(word_3),
		.last_group(last_group), .degenerate(degenerate),
		.errors(errors), .rows_pending(rows_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver side: stall at random with the odds of the current phase.
	initial out_stall = 1'b0;
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Drive one beat and hold it until the core takes it. Leave valid high
	// on return so back-to-back beats never drop it within one time step.
	task automatic send_beat(logic signed [31:0] ex, ey, ez, cx, cy, cz, ux, uy, uz);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < send_idle_pct)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		eye_x <= ex;
		eye_y <= ey;
		eye_z <= ez;
		center_x <= cx;
		center_y <= cy;
		center_z <= cz;
		up_x <= ux;
		up_y <= uy;
		up_z <= uz;
		do @(posedge clk); while (in_stall);
	endtask

	// Hold off the sender until the checker has every row it is owed.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (rows_pending != 0)
			@(posedge clk);
	endtask

	// Coordinates of mixed scale: mostly moderate, some full range, some extremes.
	function automatic logic signed [31:0] any_coord();
		logic signed [31:0] v;
		case ($urandom_range(0, 9))
			0, 1: v = $urandom;
			2: v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			3: v = '0;
			default: begin
				v = $urandom >> $urandom_range(6, 28);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] near_coord();
		logic signed [31:0] v;
		v = $urandom >> $urandom_range(10, 24);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	task automatic random_item();
		logic signed [31:0] ex, ey, ez, cx, cy, cz, ux, uy, uz;
		ex = near_coord();
		ey = near_coord();
		ez = near_coord();
		cx = near_coord();
		cy = near_coord();
		cz = near_coord();
		ux = near_coord();
		uy = near_coord();
		uz = near_coord();
		case ($urandom_range(0, 9))
			0, 1: begin
				// full-range noise, reaches saturation and every input bit
				ex = any_coord(); ey = any_coord(); ez = any_coord();
				cx = any_coord(); cy = any_coord(); cz = any_coord();
				ux = any_coord(); uy = any_coord(); uz = any_coord();
			end
			2: begin
				// up along the view direction
				ux = cx - ex; uy = cy - ey; uz = cz - ez;
			end
			3: begin
				// eye on the target or a zero up vector
				if ($urandom_range(0, 1)) begin
					cx = ex; cy = ey; cz = ez;
				end else begin
					ux = '0; uy = '0; uz = '0;
				end
			end
			default: ;
		endcase
		send_beat(ex, ey, ez, cx, cy, cz, ux, uy, uz);
	endtask

	localparam logic signed [31:0] ONE = 32'sd1 <<< lavm_pkg::FRAC_BITS_DEF;
	localparam logic signed [31:0] PMAX = 32'sh7fffffff;
	localparam logic signed [31:0] NMAX = 32'sh80000000;

	initial begin
		int waited;
		arst_n = 1'b0;
		in_valid = 1'b0;
		{eye_x, eye_y, eye_z, center_x, center_y, center_z, up_x, up_y, up_z} = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: textbook camera, axis cases, degenerate set-ups, extremes.
		send_beat(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0);
		send_beat(ONE, 2 * ONE, 3 * ONE, -ONE, 0, ONE, 0, 0, ONE);
		send_beat(0, 0, 0, 0, 0, 0, 0, ONE, 0);
		send_beat(3, 4, 5, 3, 4, 5, 0, 0, 0);
		send_beat(0, 0, 0, 0, 0, ONE, 0, 0, 7 * ONE);
		send_beat(0, 0, 0, 0, 0, ONE, 0, 0, -ONE);
		send_beat(ONE, ONE, ONE, 0, 0, 0, 0, 0, 0);
		send_beat(NMAX, NMAX, NMAX, PMAX, PMAX, PMAX, 0, ONE, 0);
		send_beat(PMAX, PMAX, PMAX, NMAX, NMAX, NMAX, ONE, 0, 0);
		send_beat(PMAX, NMAX, PMAX, NMAX, PMAX, 0, PMAX, NMAX, 1);
		send_beat(NMAX, PMAX, NMAX, 0, 0, 0, NMAX, NMAX, NMAX);
		send_beat(PMAX, 0, 0, 0, 0, 0, 0, PMAX, 0);
		send_beat(1, 0, 0, 0, 0, 0, 0, 1, 0);
		send_beat(-1, -1, -1, 0, 0, 0, -1, 0, 1);
		send_beat(-32'sd1, 32'sh00010000, 0, 32'sh7fff0000, -32'sd7, 32'sh12345678,
			32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f);
		send_beat(32'shfffffffe, 32'sh00000002, 32'sh40000000, 0, 0, 0, 3, 3, 3);
		send_beat(0, 10 * ONE, 0, 0, 0, 0, 0, ONE, 0);

		// Pause with everything drained before the random part.
		drain();

		// Random: four idling phases, each a quarter of the items.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 64; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 64; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			for (int n = 0; n < RANDOM_ITEMS / 4; n++)
				random_item();
		end
		in_valid <= 1'b0;
		recv_stall_pct = 0;

		// Wait for the last rows, then for the pipeline latency on top.
		waited = 0;
		while (rows_pending != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY + 10) @(posedge clk);

		if (errors == 0 && rows_pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
